### sv/tgl_pkg.sv
// shared types and constants of the text glyph layout block
// depends on nothing; imported by tgl_front, tgl_back and the top level
`default_nettype none

package tgl_pkg;

  // character codes that steer the layout
  localparam logic [7:0] CH_NEWLINE     = 8'h0A;
  localparam logic [7:0] CH_SPACE       = 8'h20;
  localparam logic [7:0] CH_HASH        = 8'h23;
  localparam logic [7:0] CH_AT          = 8'h40;
  localparam logic [7:0] CH_BRACE_OPEN  = 8'h7B;
  localparam logic [7:0] CH_BRACE_CLOSE = 8'h7D;

  localparam logic [31:0] COLOR_WHITE = 32'hFFFF_FFFF;
  localparam logic [3:0]  HEX_DIGITS  = 4'd8;

  localparam logic KIND_GLYPH = 1'b0;
  localparam logic KIND_PEN   = 1'b1;

  // what the back end does with the pen for one character
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_GLYPH,
    ACT_SPACE,
    ACT_NEWLINE
  } act_e;

  // classified character handed from front to back
  typedef struct packed {
    logic               load;
    logic signed [31:0] axis_a;
    logic signed [31:0] axis_b;
    logic signed [31:0] axis_c;
    logic signed [31:0] axis_d;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    act_e               act;
    logic [7:0]         atlas_x;
    logic [7:0]         atlas_y;
    logic [31:0]        color;
    logic               end_flag;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic               kind;
    logic [7:0]         atlas_x;
    logic [7:0]         atlas_y;
    logic [31:0]        color;
    logic signed [31:0] pen_x;
    logic signed [31:0] pen_y;
    logic               last;
  } res_t;

  // uppercase hex digit value, anything else counts as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h41 + 8'd10);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### sv/tgl_fifo.sv
// small flop-based queue used between the stages and on the result side
// depends on nothing; width and depth come from parameters
`default_nettype none

module tgl_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  // status and head of queue
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### sv/tgl_front.sv
// front end: tag parsing, color tracking and character classification
// depends on tgl_pkg; feeds classified transactions to the command queue
`default_nettype none

module tgl_front
  import tgl_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [7:0]         ch_i,
  input  wire logic               first_i,
  input  wire logic signed [31:0] axis_a_i,
  input  wire logic signed [31:0] axis_b_i,
  input  wire logic signed [31:0] axis_c_i,
  input  wire logic signed [31:0] axis_d_i,
  input  wire logic signed [31:0] origin_x_i,
  input  wire logic signed [31:0] origin_y_i,
  input  wire logic               end_of_text_i,
  output cmd_t                    cmd_o
);

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_BRACE,
    MODE_HEX,
    MODE_ICON
  } mode_e;

  mode_e       mode_q, mode_d, mode_eff;
  logic [3:0]  cnt_q, cnt_d, cnt_eff, cnt_inc;
  logic [31:0] acc_q, acc_d, acc_eff;
  logic [31:0] color_q, color_d, color_eff;
  act_e        act;
  logic        plain;

  // tag state after an optional string start
  always_comb begin
    mode_eff  = first_i ? MODE_PLAIN : mode_q;
    cnt_eff   = first_i ? 4'd0 : cnt_q;
    acc_eff   = first_i ? 32'd0 : acc_q;
    color_eff = first_i ? COLOR_WHITE : color_q;
  end

  assign cnt_inc = cnt_eff + 4'd1;

  // tag parser
  always_comb begin
    mode_d  = mode_eff;
    cnt_d   = cnt_eff;
    acc_d   = acc_eff;
    color_d = color_eff;
    plain   = 1'b0;
    unique case (mode_eff)
      MODE_HEX: begin
        if (cnt_eff < HEX_DIGITS) begin
          acc_d = {acc_eff[27:0], hex_value(ch_i)};
          cnt_d = cnt_inc;
          if (cnt_inc == HEX_DIGITS) begin
            color_d = acc_d;
          end
        end else begin
          // closing character of the color tag is swallowed
          mode_d = MODE_PLAIN;
          cnt_d  = 4'd0;
        end
      end
      MODE_ICON: begin
        if (ch_i == CH_BRACE_CLOSE) begin
          mode_d = MODE_PLAIN;
        end
      end
      MODE_BRACE: begin
        if (ch_i == CH_HASH) begin
          mode_d = MODE_HEX;
          cnt_d  = 4'd0;
          acc_d  = 32'd0;
        end else if (ch_i == CH_AT) begin
          mode_d = MODE_ICON;
        end else if (ch_i != CH_BRACE_OPEN) begin
          mode_d = MODE_PLAIN;
          plain  = 1'b1;
        end
      end
      MODE_PLAIN: begin
        plain = 1'b1;
      end
      default: begin
        mode_d = MODE_PLAIN;
      end
    endcase

    // plain character classification
    act = ACT_NONE;
    if (plain) begin
      priority if (ch_i == CH_BRACE_OPEN) begin
        mode_d = MODE_BRACE;
      end else if (ch_i == CH_SPACE) begin
        act = ACT_SPACE;
      end else if (ch_i == CH_NEWLINE) begin
        act = ACT_NEWLINE;
      end else begin
        act = ACT_GLYPH;
      end
    end

    // end of text closes any open tag
    if (end_of_text_i) begin
      mode_d = MODE_PLAIN;
      cnt_d  = 4'd0;
      acc_d  = 32'd0;
    end
  end

  // transaction toward the back end
  always_comb begin
    cmd_o.load     = first_i;
    cmd_o.axis_a   = axis_a_i;
    cmd_o.axis_b   = axis_b_i;
    cmd_o.axis_c   = axis_c_i;
    cmd_o.axis_d   = axis_d_i;
    cmd_o.origin_x = origin_x_i;
    cmd_o.origin_y = origin_y_i;
    cmd_o.act      = act;
    cmd_o.atlas_x  = {ch_i[4:0], 3'b000};
    cmd_o.atlas_y  = {1'b0, ch_i[7:5], 4'b0000};
    cmd_o.color    = color_eff;
    cmd_o.end_flag = end_of_text_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_PLAIN;
      cnt_q   <= 4'd0;
      acc_q   <= 32'd0;
      color_q <= COLOR_WHITE;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      color_q <= color_d;
    end
  end

endmodule

`default_nettype wire

### sv/tgl_back.sv
// back end: pen and line origin tracking, result generation
// depends on tgl_pkg; reads the command queue and writes the result queue
`default_nettype none

module tgl_back
  import tgl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  input  wire logic res_full_i,
  output logic      res_push_o,
  output res_t      res_o
);

  logic [31:0] pen_x_q, pen_y_q, line_x_q, line_y_q;
  logic [31:0] ax_a_q, ax_b_q, ax_c_q, ax_d_q;
  logic [31:0] a, b, c, d;
  logic [31:0] pen_x, pen_y, line_x, line_y;
  logic [31:0] pen_x_d, pen_y_d, line_x_d, line_y_d;
  logic [31:0] step_x, step_y, drop_x, drop_y;
  logic        split_q, split_d;
  logic        is_glyph, go;

  // axes and pen seen by this transaction
  always_comb begin
    a      = cmd_i.load ? 32'(cmd_i.axis_a)   : ax_a_q;
    b      = cmd_i.load ? 32'(cmd_i.axis_b)   : ax_b_q;
    c      = cmd_i.load ? 32'(cmd_i.axis_c)   : ax_c_q;
    d      = cmd_i.load ? 32'(cmd_i.axis_d)   : ax_d_q;
    pen_x  = cmd_i.load ? 32'(cmd_i.origin_x) : pen_x_q;
    pen_y  = cmd_i.load ? 32'(cmd_i.origin_y) : pen_y_q;
    line_x = cmd_i.load ? 32'(cmd_i.origin_x) : line_x_q;
    line_y = cmd_i.load ? 32'(cmd_i.origin_y) : line_y_q;
  end

  // constant multiples as shift-add, wrapping mod 2^32
  assign step_x = (a << 2) + (a << 1);
  assign step_y = (b << 2) + (b << 1);
  assign drop_x = (c << 3) + (c << 1) + c;
  assign drop_y = (d << 3) + (d << 1) + d;

  // pen move
  always_comb begin
    pen_x_d  = pen_x;
    pen_y_d  = pen_y;
    line_x_d = line_x;
    line_y_d = line_y;
    unique case (cmd_i.act)
      ACT_GLYPH, ACT_SPACE: begin
        pen_x_d = pen_x + step_x;
        pen_y_d = pen_y + step_y;
      end
      ACT_NEWLINE: begin
        line_x_d = line_x - drop_x;
        line_y_d = line_y - drop_y;
        pen_x_d  = line_x_d;
        pen_y_d  = line_y_d;
      end
      default: begin
      end
    endcase
  end

  assign is_glyph = (cmd_i.act == ACT_GLYPH);

  // result selection and queue handshakes
  always_comb begin
    res_o.kind    = KIND_PEN;
    res_o.atlas_x = 8'd0;
    res_o.atlas_y = 8'd0;
    res_o.color   = 32'd0;
    res_o.last    = 1'b1;
    res_o.pen_x   = $signed(pen_x_d);
    res_o.pen_y   = $signed(pen_y_d);
    split_d       = split_q;
    if (split_q) begin
      // second result of a glyph on the final character
      go          = cmd_valid_i && !res_full_i;
      res_o.pen_x = $signed(pen_x_q);
      res_o.pen_y = $signed(pen_y_q);
      res_push_o  = go;
      cmd_pop_o   = go;
      if (go) begin
        split_d = 1'b0;
      end
    end else begin
      go = cmd_valid_i && (!res_full_i || (!is_glyph && !cmd_i.end_flag));
      if (is_glyph) begin
        res_o.kind    = KIND_GLYPH;
        res_o.atlas_x = cmd_i.atlas_x;
        res_o.atlas_y = cmd_i.atlas_y;
        res_o.color   = cmd_i.color;
        res_o.last    = 1'b0;
        res_o.pen_x   = $signed(pen_x);
        res_o.pen_y   = $signed(pen_y);
      end
      res_push_o = go && (is_glyph || cmd_i.end_flag);
      cmd_pop_o  = go && !(is_glyph && cmd_i.end_flag);
      split_d    = go && is_glyph && cmd_i.end_flag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_q  <= 1'b0;
      pen_x_q  <= 32'd0;
      pen_y_q  <= 32'd0;
      line_x_q <= 32'd0;
      line_y_q <= 32'd0;
      ax_a_q   <= 32'd0;
      ax_b_q   <= 32'd0;
      ax_c_q   <= 32'd0;
      ax_d_q   <= 32'd0;
    end else begin
      split_q <= split_d;
      if (go && !split_q) begin
        pen_x_q  <= pen_x_d;
        pen_y_q  <= pen_y_d;
        line_x_q <= line_x_d;
        line_y_q <= line_y_d;
        ax_a_q   <= a;
        ax_b_q   <= b;
        ax_c_q   <= c;
        ax_d_q   <= d;
      end
    end
  end

endmodule

`default_nettype wire

### sv/text_glyph_layout.sv
// Text glyph layout: takes one character per cycle and returns glyph sprites
// and the final pen position. An input transaction is accepted in every cycle
// while the command queue has room; the result side delivers at most one
// result per cycle. A glyph on the final character of a string makes two
// results, and the back end holds that character until both are queued.
// A taken character goes through the command queue and the back end into the
// result queue, whose head drives the ports; the back end's pen update is a shift-add.
`default_nettype none

module text_glyph_layout
  import tgl_pkg::*;
#(
  parameter int unsigned CMD_DEPTH = 2,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         ch_i,
  input  wire logic               first_i,
  input  wire logic signed [31:0] axis_a_i,
  input  wire logic signed [31:0] axis_b_i,
  input  wire logic signed [31:0] axis_c_i,
  input  wire logic signed [31:0] axis_d_i,
  input  wire logic signed [31:0] origin_x_i,
  input  wire logic signed [31:0] origin_y_i,
  input  wire logic               end_of_text_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic                    kind_o,
  output logic [7:0]              atlas_x_o,
  output logic [7:0]              atlas_y_o,
  output logic [7:0]              red_o,
  output logic [7:0]              green_o,
  output logic [7:0]              blue_o,
  output logic [7:0]              alpha_o,
  output logic signed [31:0]      pen_x_o,
  output logic signed [31:0]      pen_y_o,
  output logic                    last_o
);

  cmd_t cmd_in, cmd_head;
  res_t res_in, res_head;
  logic accept;
  logic cmd_empty, cmd_pop;
  logic res_full, res_push;

  assign accept = push && !full;

  // character classification
  tgl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .ch_i          (ch_i),
    .first_i       (first_i),
    .axis_a_i      (axis_a_i),
    .axis_b_i      (axis_b_i),
    .axis_c_i      (axis_c_i),
    .axis_d_i      (axis_d_i),
    .origin_x_i    (origin_x_i),
    .origin_y_i    (origin_y_i),
    .end_of_text_i (end_of_text_i),
    .cmd_o         (cmd_in)
  );

  // queue between front and back
  tgl_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .empty_o (cmd_empty)
  );

  // pen tracking and result generation
  tgl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // result queue toward the consumer
  tgl_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_head),
    .empty_o (empty)
  );

  // result fields
  assign kind_o    = res_head.kind;
  assign atlas_x_o = res_head.atlas_x;
  assign atlas_y_o = res_head.atlas_y;
  assign red_o     = res_head.color[31:24];
  assign green_o   = res_head.color[23:16];
  assign blue_o    = res_head.color[15:8];
  assign alpha_o   = res_head.color[7:0];
  assign pen_x_o   = res_head.pen_x;
  assign pen_y_o   = res_head.pen_y;
  assign last_o    = res_head.last;

endmodule

`default_nettype wire

### dv/testbench.sv
// self-checking testbench for text_glyph_layout: glyph sprites and final pen
// depends on tgl_pkg and the text_glyph_layout rtl; checks against an in-bench layout predictor
`timescale 1ns / 100ps

module testbench;
  import tgl_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 400;
  localparam logic [31:0] ADV_STEP  = 32'd6;
  localparam logic [31:0] LINE_STEP = 32'd11;

  typedef enum logic [1:0] {TAG_PLAIN, TAG_BRACE, TAG_COLOR, TAG_ICON} tag_state_e;

  // clock, reset and block ports
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               push          = 1'b0;
  logic               full;
  logic [7:0]         ch_i          = 8'h00;
  logic               first_i       = 1'b0;
  logic signed [31:0] axis_a_i      = '0;
  logic signed [31:0] axis_b_i      = '0;
  logic signed [31:0] axis_c_i      = '0;
  logic signed [31:0] axis_d_i      = '0;
  logic signed [31:0] origin_x_i    = '0;
  logic signed [31:0] origin_y_i    = '0;
  logic               end_of_text_i = 1'b0;
  logic               empty;
  logic               pop           = 1'b0;
  logic               kind_o;
  logic [7:0]         atlas_x_o;
  logic [7:0]         atlas_y_o;
  logic [7:0]         red_o;
  logic [7:0]         green_o;
  logic [7:0]         blue_o;
  logic [7:0]         alpha_o;
  logic signed [31:0] pen_x_o;
  logic signed [31:0] pen_y_o;
  logic               last_o;

  // layout predictor state, reset values
  logic [31:0] pen_x     = '0;
  logic [31:0] pen_y     = '0;
  logic [31:0] line_x    = '0;
  logic [31:0] line_y    = '0;
  logic [31:0] adv_x     = '0;
  logic [31:0] adv_y     = '0;
  logic [31:0] feed_x    = '0;
  logic [31:0] feed_y    = '0;
  logic [31:0] ink_color = COLOR_WHITE;
  tag_state_e  tag_state = TAG_PLAIN;
  logic [3:0]  hex_count = '0;
  logic [31:0] hex_accum = '0;

  res_t        pending_results[$];
  logic [7:0]  text_buf[$];
  int          mismatch_count = 0;
  int          chars_sent     = 0;
  int          quiet_cycles   = 0;
  int          hold_request   = 0;
  int          hold_left      = 0;
  int          pop_idle_left  = 0;
  bit          tx_idle_en     = 1'b1;
  bit          rx_idle_en     = 1'b1;

  text_glyph_layout uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .ch_i          (ch_i),
    .first_i       (first_i),
    .axis_a_i      (axis_a_i),
    .axis_b_i      (axis_b_i),
    .axis_c_i      (axis_c_i),
    .axis_d_i      (axis_d_i),
    .origin_x_i    (origin_x_i),
    .origin_y_i    (origin_y_i),
    .end_of_text_i (end_of_text_i),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (kind_o),
    .atlas_x_o     (atlas_x_o),
    .atlas_y_o     (atlas_y_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .alpha_o       (alpha_o),
    .pen_x_o       (pen_x_o),
    .pen_y_o       (pen_y_o),
    .last_o        (last_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // layout predictor

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
    return 4'd0;
  endfunction

  task automatic queue_result(input logic kind, input logic [7:0] ax, input logic [7:0] ay,
                              input logic [31:0] color, input logic last);
    res_t r;
    r.kind    = kind;
    r.atlas_x = ax;
    r.atlas_y = ay;
    r.color   = color;
    r.pen_x   = pen_x;
    r.pen_y   = pen_y;
    r.last    = last;
    pending_results.push_back(r);
  endtask

  // plain text handling: brace, space, newline or glyph
  task automatic place_plain(input logic [7:0] c);
    if (c == CH_BRACE_OPEN) begin
      tag_state = TAG_BRACE;
    end else if (c == CH_SPACE) begin
      pen_x = pen_x + ADV_STEP * adv_x;
      pen_y = pen_y + ADV_STEP * adv_y;
    end else if (c == CH_NEWLINE) begin
      line_x = line_x - LINE_STEP * feed_x;
      line_y = line_y - LINE_STEP * feed_y;
      pen_x  = line_x;
      pen_y  = line_y;
    end else begin
      queue_result(KIND_GLYPH, {c[4:0], 3'b000}, {1'b0, c[7:5], 4'b0000}, ink_color, 1'b0);
      pen_x = pen_x + ADV_STEP * adv_x;
      pen_y = pen_y + ADV_STEP * adv_y;
    end
  endtask

  task automatic predict_layout(input logic [7:0] c, input logic is_first, input logic is_end,
                                input logic [31:0] a, input logic [31:0] b,
                                input logic [31:0] cc, input logic [31:0] d,
                                input logic [31:0] ox, input logic [31:0] oy);
    if (is_first) begin
      adv_x     = a;
      adv_y     = b;
      feed_x    = cc;
      feed_y    = d;
      pen_x     = ox;
      pen_y     = oy;
      line_x    = ox;
      line_y    = oy;
      ink_color = COLOR_WHITE;
      tag_state = TAG_PLAIN;
      hex_count = '0;
      hex_accum = '0;
    end
    case (tag_state)
      TAG_COLOR: begin
        if (hex_count < HEX_DIGITS) begin
          hex_accum = {hex_accum[27:0], digit_value(c)};
          hex_count = hex_count + 4'd1;
          if (hex_count == HEX_DIGITS) ink_color = hex_accum;
        end else begin
          // closing character of the color tag, consumed as is
          tag_state = TAG_PLAIN;
          hex_count = '0;
        end
      end
      TAG_ICON: begin
        if (c == CH_BRACE_CLOSE) tag_state = TAG_PLAIN;
      end
      TAG_BRACE: begin
        if (c == CH_HASH) begin
          tag_state = TAG_COLOR;
          hex_count = '0;
          hex_accum = '0;
        end else if (c == CH_AT) begin
          tag_state = TAG_ICON;
        end else if (c != CH_BRACE_OPEN) begin
          tag_state = TAG_PLAIN;
          place_plain(c);
        end
      end
      default: begin
        place_plain(c);
      end
    endcase
    if (is_end) begin
      queue_result(KIND_PEN, 8'h00, 8'h00, 32'h0, 1'b1);
      tag_state = TAG_PLAIN;
      hex_count = '0;
      hex_accum = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic check_result();
    res_t want;
    if (pending_results.size() == 0) begin
      $display("%0t ns: result with no expectation, kind %b pen %h,%h", $time, kind_o,
               pen_x_o, pen_y_o);
      mismatch_count++;
    end else begin
      want = pending_results.pop_front();
      check_field("kind", want.kind, kind_o);
      check_field("atlas_x", want.atlas_x, atlas_x_o);
      check_field("atlas_y", want.atlas_y, atlas_y_o);
      check_field("red", want.color[31:24], red_o);
      check_field("green", want.color[23:16], green_o);
      check_field("blue", want.color[15:8], blue_o);
      check_field("alpha", want.color[7:0], alpha_o);
      check_field("pen_x", want.pen_x, pen_x_o);
      check_field("pen_y", want.pen_y, pen_y_o);
      check_field("last", want.last, last_o);
    end
  endtask

  // result side: check each popped transaction, then pick pop for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) check_result();
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (pop_idle_left > 0) begin
        pop_idle_left--;
        pop <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        pop_idle_left = $urandom_range(1, 11) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: watchdog, no transaction for %0d cycles, %0d results pending",
                 $time, quiet_cycles, pending_results.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus

  task automatic send_char(input logic [7:0] c, input logic is_first, input logic is_end,
                           input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] cc, input logic [31:0] d,
                           input logic [31:0] ox, input logic [31:0] oy);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    push          <= 1'b1;
    ch_i          <= c;
    first_i       <= is_first;
    end_of_text_i <= is_end;
    axis_a_i      <= a;
    axis_b_i      <= b;
    axis_c_i      <= cc;
    axis_d_i      <= d;
    origin_x_i    <= ox;
    origin_y_i    <= oy;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_layout(c, is_first, is_end, a, b, cc, d, ox, oy);
    chars_sent++;
  endtask

  // continuation character, axis fields carry junk
  task automatic text_char(input logic [7:0] c, input logic is_end = 1'b0);
    send_char(c, 1'b0, is_end, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // opening character with plain unit axes
  task automatic start_text(input logic [7:0] c);
    send_char(c, 1'b1, 1'b0, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000,
              32'h0064_0000, 32'h0032_0000);
  endtask

  function automatic logic [31:0] rand_axis();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = $urandom;
      1:       v = 32'h7FFF_FFFF;
      2:       v = 32'h8000_0000;
      3:       v = 32'h0000_0000;
      default: v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] hex_char(input int unsigned d);
    return (d < 10) ? 8'(8'h30 + d) : 8'(8'h41 + d - 10);
  endfunction

  // append one piece of text: printable characters, whitespace, tags or raw bytes
  task automatic add_piece();
    int n;
    case ($urandom_range(0, 15))
      7:  text_buf.push_back(CH_SPACE);
      8:  text_buf.push_back(CH_NEWLINE);
      9:  text_buf.push_back(8'($urandom_range(0, 255)));
      10, 11: begin
        text_buf.push_back(CH_BRACE_OPEN);
        text_buf.push_back(CH_HASH);
        repeat (8) begin
          if ($urandom_range(0, 7) == 0) text_buf.push_back(8'($urandom_range(0, 255)));
          else text_buf.push_back(hex_char($urandom_range(0, 15)));
        end
        if ($urandom_range(0, 5) == 0) text_buf.push_back(8'($urandom_range(0, 255)));
        else text_buf.push_back(CH_BRACE_CLOSE);
      end
      12: begin
        text_buf.push_back(CH_BRACE_OPEN);
        text_buf.push_back(CH_AT);
        n = $urandom_range(0, 4);
        repeat (n) text_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
        text_buf.push_back(CH_BRACE_CLOSE);
      end
      13: begin
        text_buf.push_back(CH_BRACE_OPEN);
        text_buf.push_back(CH_BRACE_OPEN);
        text_buf.push_back(8'($urandom_range(8'h21, 8'h7A)));
      end
      14: begin
        text_buf.push_back(CH_BRACE_OPEN);
        text_buf.push_back(8'($urandom_range(8'h00, 8'h7A)));
      end
      15: text_buf.push_back(CH_BRACE_CLOSE);
      default: text_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
    endcase
  endtask

  // one string, mostly well formed; sometimes cut inside a tag or missing its ends
  task automatic random_string();
    int          goal;
    logic        with_first;
    logic        with_end;
    logic [31:0] ax[6];
    text_buf.delete();
    goal = $urandom_range(1, 24);
    while (text_buf.size() < goal) add_piece();
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) if (text_buf.size() > 1) void'(text_buf.pop_back());
    end
    with_first = ($urandom_range(0, 9) != 0);
    with_end   = ($urandom_range(0, 9) != 0);
    foreach (ax[i]) ax[i] = rand_axis();
    send_char(text_buf[0], with_first, with_end && text_buf.size() == 1,
              ax[0], ax[1], ax[2], ax[3], ax[4], ax[5]);
    for (int k = 1; k < text_buf.size(); k++) begin
      text_char(text_buf[k], with_end && k == text_buf.size() - 1);
    end
  endtask

  task automatic run_strings(input int count, input bit tx_idle, input bit rx_idle);
    int target;
    target     = chars_sent + count;
    tx_idle_en = tx_idle;
    rx_idle_en = rx_idle;
    while (chars_sent < target) random_string();
  endtask

  // ---------------------------------------------------------------------------
  // tests

  // zero axes and pen before any string has been opened
  task automatic test_before_first_string();
    text_char("A");
    text_char(CH_SPACE);
    text_char(CH_NEWLINE);
    text_char(CH_BRACE_CLOSE, 1'b1);
  endtask

  // extreme axes and origin so that pen sums wrap, extreme character codes
  task automatic test_extremes();
    send_char(8'h00, 1'b1, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              32'hFFFF_FFFF, 32'h8000_0000);
    text_char(8'hFF);
    text_char(CH_NEWLINE);
    text_char(8'h01, 1'b1);
  endtask

  // color tag with lowercase and non-hex digits, closing character not a brace
  task automatic test_color_tag();
    start_text(CH_BRACE_OPEN);
    text_char(CH_HASH);
    text_char("1");
    text_char("F");
    text_char("a");
    text_char("0");
    text_char("G");
    text_char("9");
    text_char("B");
    text_char("C");
    text_char("x");
    text_char("Q", 1'b1);
  endtask

  // icon tag skipped, double brace dropped, end of text inside an open brace
  task automatic test_icon_and_braces();
    start_text(CH_BRACE_OPEN);
    text_char(CH_AT);
    text_char("z");
    text_char(CH_BRACE_CLOSE);
    text_char(CH_BRACE_OPEN);
    text_char(CH_BRACE_OPEN);
    text_char("k");
    text_char(CH_BRACE_OPEN, 1'b1);
  endtask

  task automatic test_random_traffic();
    run_strings(500, 1'b1, 1'b1);
    run_strings(300, 1'b1, 1'b0);
    run_strings(300, 1'b0, 1'b1);
  endtask

  // receiver holds off while the sender keeps offering, block fills and stalls
  task automatic test_back_pressure();
    hold_request = HOLD_CYCLES;
    run_strings(150, 1'b0, 1'b0);
  endtask

  // last stretch with no idling on either side
  task automatic test_full_rate();
    run_strings(300, 1'b0, 1'b0);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_before_first_string();
    test_extremes();
    test_color_tag();
    test_icon_and_braces();
    test_random_traffic();
    test_back_pressure();
    test_full_rate();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
